// ===== hw/rtl/case_insensitive_signature_matcher_macros.svh =====
// ---------------------------------------------------------------------------
// signature matcher assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef CASE_INSENSITIVE_SIGNATURE_MATCHER_MACROS_SVH
`define CASE_INSENSITIVE_SIGNATURE_MATCHER_MACROS_SVH

// implication checked on every clock outside reset
`define CISM_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication outside reset
`define CISM_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/cism_pkg.sv =====
// ---------------------------------------------------------------------------
// signature matcher package
// shared types and constants
// ---------------------------------------------------------------------------
package cism_pkg;
  localparam int PatternCount = 16;
  localparam int MaxPatternLen = 64;
  localparam int SlotW = 4;
  localparam int PosW = 6;
  localparam int LenW = 7;
  localparam int SevW = 3;
  localparam int AddrW = SlotW + PosW;

  typedef enum logic [1:0] {
    OP_SCAN = 2'd0,
    OP_END = 2'd1,
    OP_WBYTE = 2'd2,
    OP_WLEN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAN = 2'd0,
    ST_FOUND = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load_byte;
    logic load_len;
    logic start_scan;
    logic step_row;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic row_last;
  } sts_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) r = c + 8'h20;
    return r;
  endfunction
endpackage

// ===== hw/rtl/case_insensitive_signature_matcher.sv =====
// ---------------------------------------------------------------------------
// case insensitive signature matcher
// top level: controller plus datapath
// ---------------------------------------------------------------------------
// one input channel (in_valid_i/in_stall_o) carries scan, end and load items;
// one output channel (out_valid_o/out_stall_i) carries one result per end item
// a scan item reads and updates one pattern row per cycle over all 16 rows;
// the row read is registered, and the controller returns to idle through S_LAST
// a load item is taken without leaving idle; an end item adds the output handshake
// the result is held in an output register until the receiver stops stalling;
// no new item is taken while it waits
// reset clears lengths, severities, progress and flags; pattern bytes are
// undefined until written and need no clearing pass
module case_insensitive_signature_matcher (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] data_byte_i,
  input  logic [3:0] pattern_slot_i,
  input  logic [5:0] byte_position_i,
  input  logic [6:0] pattern_length_i,
  input  logic [2:0] severity_in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic [1:0] status_o,
  output logic [3:0] matched_slot_o,
  output logic [2:0] severity_out_o
);
  import cism_pkg::*;
  cmd_t cmd;
  sts_t sts;

  cism_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .op_i(operation_i), .in_stall_o,
    .out_valid_o, .out_stall_i, .cmd_o(cmd), .sts_i(sts)
  );

  cism_dp u_dp (
    .clk_i, .rst_ni,
    .data_byte_i, .pattern_slot_i, .byte_position_i, .pattern_length_i,
    .severity_in_i, .cmd_i(cmd), .sts_o(sts), .status_o, .matched_slot_o,
    .severity_out_o
  );
endmodule

// ===== hw/rtl/cism_ctrl.sv =====
// ---------------------------------------------------------------------------
// signature matcher controller
// sequences scan, end and load items; a scan item steps over all pattern rows
// ---------------------------------------------------------------------------
module cism_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic [1:0] op_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cism_pkg::cmd_t cmd_o,
  input  cism_pkg::sts_t sts_i
);
  import cism_pkg::*;
  state_e state_q, state_d;
  logic acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    acc = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        acc = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.step_row = 1'b1;
        if (sts_i.row_last) state_d = S_LAST;
      end
      S_LAST: begin
        state_d = S_IDLE;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (acc) begin
      case (op_i)
        OP_SCAN: begin
          cmd_o.start_scan = 1'b1;
          state_d = S_SCAN;
        end
        OP_END: begin
          cmd_o.finish = 1'b1;
          state_d = S_OUT;
        end
        OP_WBYTE: cmd_o.load_byte = 1'b1;
        OP_WLEN: cmd_o.load_len = 1'b1;
        default: ;
      endcase
    end
  end
endmodule

// ===== hw/rtl/cism_dp.sv =====
// ---------------------------------------------------------------------------
// signature matcher datapath
// pattern memory, tables, progress vectors and result register
// ---------------------------------------------------------------------------
module cism_dp (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic [cism_pkg::SlotW-1:0] pattern_slot_i,
  input  logic [cism_pkg::PosW-1:0] byte_position_i,
  input  logic [cism_pkg::LenW-1:0] pattern_length_i,
  input  logic [cism_pkg::SevW-1:0] severity_in_i,
  input  cism_pkg::cmd_t cmd_i,
  output cism_pkg::sts_t sts_o,
  output logic [1:0] status_o,
  output logic [cism_pkg::SlotW-1:0] matched_slot_o,
  output logic [cism_pkg::SevW-1:0] severity_out_o
);
  import cism_pkg::*;

  logic [MaxPatternLen*8-1:0] mem_q [PatternCount];
  logic [LenW-1:0] len_q [PatternCount];
  logic [SevW-1:0] sev_q [PatternCount];
  logic [MaxPatternLen-1:0] prog_q [PatternCount];
  logic [PatternCount-1:0] found_q;
  logic seen_q;
  logic [7:0] byte_q;
  logic [SlotW-1:0] row_q;
  logic [1:0] status_q;
  logic [SlotW-1:0] mslot_q;
  logic [SevW-1:0] msev_q;
  logic [MaxPatternLen*8-1:0] row_data_q;
  logic [SlotW-1:0] rrow_q;
  logic rd_q;

  // one pattern row per entry, registered row read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte)
      mem_q[pattern_slot_i][{byte_position_i, 3'b000} +: 8] <= data_byte_i;
    row_data_q <= mem_q[row_q];
    rrow_q <= row_q;
  end

  logic [MaxPatternLen-1:0] hits, mask, nprog;
  logic [LenW-1:0] rlen;
  logic [PosW-1:0] last_idx;
  always_comb begin
    rlen = len_q[rrow_q];
    last_idx = PosW'(rlen - 1'b1);
    for (int j = 0; j < MaxPatternLen; j++) begin
      hits[j] = (fold_case(row_data_q[j*8 +: 8]) == byte_q);
      mask[j] = (LenW'(j) < rlen);
    end
    nprog = {prog_q[rrow_q][MaxPatternLen-2:0], 1'b1} & hits & mask;
  end

  logic found_any;
  logic [SlotW-1:0] first;
  always_comb begin
    found_any = |found_q;
    first = '0;
    for (int i = PatternCount-1; i >= 0; i--)
      if (found_q[i]) first = SlotW'(i);
  end

  assign sts_o.row_last = (row_q == SlotW'(PatternCount-1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PatternCount; i++) begin
        len_q[i] <= '0;
        sev_q[i] <= '0;
        prog_q[i] <= '0;
      end
      found_q <= '0;
      seen_q <= 1'b0;
      row_q <= '0;
      rd_q <= 1'b0;
      byte_q <= '0;
      status_q <= '0;
      mslot_q <= '0;
      msev_q <= '0;
    end else begin
      rd_q <= cmd_i.step_row;
      if (cmd_i.load_len) begin
        len_q[pattern_slot_i] <= (pattern_length_i > LenW'(MaxPatternLen)) ?
          LenW'(MaxPatternLen) : pattern_length_i;
        sev_q[pattern_slot_i] <= severity_in_i;
      end
      if (cmd_i.start_scan) begin
        byte_q <= fold_case(data_byte_i);
        seen_q <= 1'b1;
        row_q <= '0;
      end
      if (cmd_i.step_row && !sts_o.row_last) row_q <= row_q + 1'b1;
      if (rd_q && rlen != '0) begin
        prog_q[rrow_q] <= nprog;
        if (nprog[last_idx]) found_q[rrow_q] <= 1'b1;
      end
      if (cmd_i.finish) begin
        if (!seen_q) begin
          status_q <= ST_EMPTY; mslot_q <= '0; msev_q <= '0;
        end else if (found_any) begin
          status_q <= ST_FOUND; mslot_q <= first; msev_q <= sev_q[first];
        end else begin
          status_q <= ST_CLEAN; mslot_q <= '0; msev_q <= '0;
        end
        for (int i = 0; i < PatternCount; i++) prog_q[i] <= '0;
        found_q <= '0;
        seen_q <= 1'b0;
      end
    end
  end

  assign status_o = status_q;
  assign matched_slot_o = mslot_q;
  assign severity_out_o = msev_q;
endmodule

// ===== hw/rtl/cism_checker.sv =====
// ---------------------------------------------------------------------------
// signature matcher checker
// port level assertions bound to the top level
// ---------------------------------------------------------------------------
`include "case_insensitive_signature_matcher_macros.svh"
module cism_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [1:0] status_o,
  input logic [3:0] matched_slot_o,
  input logic [2:0] severity_out_o
);
  import cism_pkg::*;
  `CISM_ASSERT_IMP(a_no_take_while_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `CISM_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o, status_o <= ST_EMPTY)
  `CISM_ASSERT_IMP(a_zero_when_clean, clk_i, rst_ni, out_valid_o && status_o != ST_FOUND,
    matched_slot_o == 4'd0 && severity_out_o == 3'd0)
  `CISM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o))
endmodule

bind case_insensitive_signature_matcher cism_checker u_cism_checker (.*);
